FILE: hdl/tedq_pkg.sv
// Package for the timed event queue: item codes, stored entry layout,
// controller states and the command/status bundles. No dependencies.
package tedq_pkg;

  localparam int unsigned TimeW   = 31;
  localparam int unsigned VoiceW  = 16;
  localparam int unsigned DurW    = 31;
  localparam int unsigned HandleW = 25;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_REWIND = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  // handle holds arg_handle, arg_count << 16 and is_meta << 24
  typedef struct packed {
    logic [TimeW-1:0]   ev_time;
    logic [VoiceW-1:0]  voice;
    logic [DurW-1:0]    dur;
    logic [HandleW-1:0] handle;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LD_RD,
    S_LD_CMP,
    S_TK_RD,
    S_TK_CMP,
    S_TK_PUSH,
    S_TK_LAST
  } state_e;

  typedef struct packed {
    logic latch_in;
    logic ld_init;
    logic rd_en;
    logic rd_sel_idx;
    logic wr_en;
    logic wr_sel_new;
    logic pos_dec;
    logic ld_done;
    logic rewind;
    logic pend_load;
    logic idx_inc;
    logic emit;
    logic emit_last;
    logic tick_done;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic playing;
    logic pos_zero;
    logic shift_hit;
    logic idx_end;
    logic due;
    logic pend_valid;
    logic out_free;
  } status_t;

endpackage

FILE: hdl/tedq_if.sv
// Request channels of the timed event queue: load/rewind/tick in, events out.
// Depends on nothing.
interface tedq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [30:0] event_time;
  logic        is_meta;
  logic [7:0]  voice_first;
  logic [7:0]  voice_last;
  logic [30:0] duration;
  logic [15:0] arg_handle;
  logic [7:0]  arg_count;

  modport source (output valid, kind, event_time, is_meta, voice_first, voice_last,
                  duration, arg_handle, arg_count, input ready);
  modport sink (input valid, kind, event_time, is_meta, voice_first, voice_last,
                duration, arg_handle, arg_count, output ready);
endinterface

interface tedq_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] out_time;
  logic        out_is_meta;
  logic [7:0]  out_voice_first;
  logic [7:0]  out_voice_last;
  logic [30:0] out_duration;
  logic [15:0] out_arg_handle;
  logic [7:0]  out_arg_count;
  logic        last_of_tick;

  modport source (output valid, out_time, out_is_meta, out_voice_first, out_voice_last,
                  out_duration, out_arg_handle, out_arg_count, last_of_tick,
                  input ready);
  modport sink (input valid, out_time, out_is_meta, out_voice_first, out_voice_last,
                out_duration, out_arg_handle, out_arg_count, last_of_tick,
                output ready);
endinterface

FILE: hdl/tedq_ram.sv
// Generic single write port, single read port RAM with registered read.
// Depends on nothing.
module tedq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

FILE: hdl/tedq_ctrl.sv
// Controller state machine of the timed event queue.
// Depends on tedq_pkg; drives tedq_dp through cmd_t, watches status_t.
module tedq_ctrl
  import tedq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_kind_i,
  input  status_t    status_i,
  output logic       in_ready_o,
  output cmd_t       cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          case (kind_e'(in_kind_i))
            KIND_LOAD: begin
              if (!status_i.full) begin
                cmd_o.ld_init = 1'b1;
                state_d       = S_LD_RD;
              end
            end
            KIND_REWIND: cmd_o.rewind = 1'b1;
            KIND_TICK: begin
              if (status_i.playing) begin
                state_d = S_TK_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_LD_RD: begin
        if (status_i.pos_zero) begin
          cmd_o.wr_en      = 1'b1;
          cmd_o.wr_sel_new = 1'b1;
          cmd_o.ld_done    = 1'b1;
          state_d          = S_IDLE;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_LD_CMP;
        end
      end
      S_LD_CMP: begin
        cmd_o.wr_en = 1'b1;
        if (status_i.shift_hit) begin
          // move the later entry up one slot and keep looking
          cmd_o.pos_dec = 1'b1;
          state_d       = S_LD_RD;
        end else begin
          cmd_o.wr_sel_new = 1'b1;
          cmd_o.ld_done    = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_TK_RD: begin
        if (status_i.idx_end) begin
          if (status_i.pend_valid) begin
            state_d = S_TK_LAST;
          end else begin
            cmd_o.tick_done = 1'b1;
            state_d         = S_IDLE;
          end
        end else begin
          cmd_o.rd_en      = 1'b1;
          cmd_o.rd_sel_idx = 1'b1;
          state_d          = S_TK_CMP;
        end
      end
      S_TK_CMP: begin
        if (status_i.due) begin
          if (status_i.pend_valid) begin
            state_d = S_TK_PUSH;
          end else begin
            cmd_o.pend_load = 1'b1;
            cmd_o.idx_inc   = 1'b1;
            state_d         = S_TK_RD;
          end
        end else if (status_i.pend_valid) begin
          state_d = S_TK_LAST;
        end else begin
          cmd_o.tick_done = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_TK_PUSH: begin
        // another event is due, so the held one is not the last
        if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.pend_load = 1'b1;
          cmd_o.idx_inc   = 1'b1;
          state_d         = S_TK_RD;
        end
      end
      S_TK_LAST: begin
        if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = 1'b1;
          cmd_o.tick_done = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

FILE: hdl/tedq_dp.sv
// Datapath of the timed event queue: event RAM, counters, held event and
// output register. Depends on tedq_pkg, tedq_ram, tedq_if.
module tedq_dp
  import tedq_pkg::*;
#(
  parameter int unsigned Depth = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  tedq_in_if.sink        in_i,
  tedq_out_if.source     out_o,
  input  cmd_t           cmd_i,
  output status_t        status_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [CW-1:0] DepthC = CW'(Depth);

  logic [CW-1:0] count_q, idx_q;
  logic [AW-1:0] pos_q;
  logic [31:0]   elapsed_q;
  logic          playing_q, pend_valid_q, out_valid_q;
  entry_t        new_q, pend_q, rdata;
  logic          last_q;
  entry_t        wdata;
  logic [AW-1:0] raddr;

  assign raddr = cmd_i.rd_sel_idx ? idx_q[AW-1:0] : (pos_q - AW'(1));
  assign wdata = cmd_i.wr_sel_new ? new_q : rdata;

  tedq_ram #(.Width($bits(entry_t)), .Depth(Depth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (pos_q),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // zero note fields of a meta event on the way in
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      new_q.ev_time <= in_i.event_time;
      new_q.voice   <= in_i.is_meta ? '0 : {in_i.voice_last, in_i.voice_first};
      new_q.dur     <= in_i.is_meta ? '0 : in_i.duration;
      new_q.handle  <= {in_i.is_meta, in_i.is_meta ? 8'd0 : in_i.arg_count,
                        in_i.arg_handle};
    end
    if (cmd_i.pend_load) begin
      pend_q <= rdata;
    end
    if (cmd_i.emit) begin
      out_o.out_time        <= pend_q.ev_time;
      out_o.out_is_meta     <= pend_q.handle[24];
      out_o.out_voice_first <= pend_q.voice[7:0];
      out_o.out_voice_last  <= pend_q.voice[15:8];
      out_o.out_duration    <= pend_q.dur;
      out_o.out_arg_handle  <= pend_q.handle[15:0];
      out_o.out_arg_count   <= pend_q.handle[23:16];
      last_q                <= cmd_i.emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      idx_q        <= '0;
      pos_q        <= '0;
      elapsed_q    <= '0;
      playing_q    <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.ld_init) begin
        pos_q <= count_q[AW-1:0];
      end else if (cmd_i.pos_dec) begin
        pos_q <= pos_q - AW'(1);
      end
      if (cmd_i.ld_done) begin
        count_q <= count_q + CW'(1);
        // keep the next due event the same when inserting ahead of it
        if (CW'(pos_q) < idx_q) begin
          idx_q <= idx_q + CW'(1);
        end
      end
      if (cmd_i.rewind) begin
        idx_q     <= '0;
        elapsed_q <= '0;
        playing_q <= 1'b1;
      end
      if (cmd_i.idx_inc) begin
        idx_q <= idx_q + CW'(1);
      end
      if (cmd_i.pend_load) begin
        pend_valid_q <= 1'b1;
      end
      if (cmd_i.tick_done) begin
        pend_valid_q <= 1'b0;
        elapsed_q    <= elapsed_q + 32'd1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.last_of_tick = last_q;

  assign status_o.full       = (count_q == DepthC);
  assign status_o.playing    = playing_q;
  assign status_o.pos_zero   = (pos_q == '0);
  assign status_o.shift_hit  = (rdata.ev_time > new_q.ev_time);
  assign status_o.idx_end    = (idx_q >= count_q);
  assign status_o.due        = ({1'b0, rdata.ev_time} <= elapsed_q);
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.out_free   = !out_valid_q || out_o.ready;
endmodule

FILE: hdl/timed_event_queue_core.sv
// Timed event queue: keeps up to Depth note/meta events sorted by start tick
// and plays them back one tick request at a time.
// in_i takes three request kinds: load (insert an event in time order, stable
// for equal times; dropped when the queue is full), rewind (restart playback
// at the head with the elapsed count at zero) and tick.
// A tick emits every event due by the elapsed count on out_o, the final one
// flagged by last_of_tick, then advances the count. One request is handled
// at a time; in_i.ready is high while the controller is idle.
// Load walks down from the tail over the event RAM (one write port, one
// read port) by read, compare and write, moving each stored entry with a
// later time up one slot until the walk meets an earlier entry or slot 0.
// Rewind, or a tick while stopped, finishes in the idle state. A tick in
// playback reads entries from the scan index and holds each due event until
// the next read shows whether it is the last; a stalled receiver stalls it.
// Results sit in an output register; a stalled receiver holds it and the
// controller waits on the next emit, so nothing is lost.
// Reset clears counters and the playing flag; RAM contents need no clearing
// as only slots below the event count are read.
module timed_event_queue_core
  import tedq_pkg::*;
#(
  parameter int unsigned Depth = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tedq_in_if.sink    in_i,
  tedq_out_if.source out_o
);
  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign in_i.ready = in_ready;

  tedq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_i.kind),
    .status_i   (status),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  tedq_dp #(.Depth(Depth)) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .out_o    (out_o),
    .cmd_i    (cmd),
    .status_o (status)
  );
endmodule
